FILE: design/lbsq_pkg.sv
// ----------------------------------------------------------------------------
// lbsq_pkg
// Shared types, constants and helpers for the LED blink sequence queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lbsq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int LED_COUNT   = 8;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // opcodes
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_QUIT    = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // phase codes of a slot
  localparam logic [1:0] PH_BEGIN = 2'd0;
  localparam logic [1:0] PH_ON    = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;

  // configuration register indexes
  localparam logic CFG_UPDATE_INTERVAL = 1'b0;
  localparam logic CFG_LED_ENABLE_MASK = 1'b1;

  localparam logic [15:0] UPDATE_INTERVAL_RESET = 16'd10;
  localparam logic [15:0] REPEAT_FOREVER        = 16'hFFFF;

  typedef struct packed {
    logic       loaded;
    logic       started;
    logic       done;
    logic [1:0] phase;
    logic [2:0] led;
  } slot_flags_t;

  typedef struct packed {
    logic [15:0] on_time;
    logic [15:0] start_delay;
    logic [15:0] end_delay;
    logic [15:0] repeat_count;
    logic [15:0] pass_count;
    logic [31:0] phase_stamp;
  } slot_word_t;

  localparam int WORD_W = $bits(slot_word_t);

  typedef struct packed {
    logic       en;
    logic       on;
    logic [2:0] led;
  } drive_t;

  function automatic logic [7:0] apply_drive(logic [7:0] level, logic [2:0] led,
                                             logic on, logic [7:0] mask);
    logic [7:0] result;
    result = level;
    if ((int'(led) < LED_COUNT) && mask[led]) begin
      result[led] = on;
    end
    return result;
  endfunction

endpackage

`default_nettype wire

FILE: design/lbsq_ram.sv
// ----------------------------------------------------------------------------
// lbsq_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lbsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/lbsq_step_unit.sv
// ----------------------------------------------------------------------------
// lbsq_step_unit
// Advances one slot by one sweep: start, phase timing and repeat decision.
// ----------------------------------------------------------------------------
`default_nettype none

module lbsq_step_unit (
  input  wire logic [31:0]          now,
  input  wire lbsq_pkg::slot_flags_t flags_in,
  input  wire lbsq_pkg::slot_word_t  word_in,
  output lbsq_pkg::slot_flags_t      flags_out,
  output lbsq_pkg::slot_word_t       word_out,
  output lbsq_pkg::drive_t           drive
);

  logic        start;
  logic [31:0] last;
  logic [31:0] elapsed;
  logic [15:0] threshold;
  logic        expired;
  logic        again;

  always_comb begin
    start   = flags_in.loaded & ~flags_in.started & ~flags_in.done;
    last    = start ? now : word_in.phase_stamp;
    elapsed = now - last;

    case (flags_in.phase & {2{~start}})
      lbsq_pkg::PH_BEGIN: threshold = word_in.start_delay;
      lbsq_pkg::PH_ON:    threshold = word_in.on_time;
      default:            threshold = word_in.end_delay;
    endcase
    expired = elapsed >= {16'd0, threshold};

    again = (!word_in.repeat_count[15] && (word_in.repeat_count != 16'd0)
             && (word_in.pass_count < word_in.repeat_count))
            || (word_in.repeat_count == lbsq_pkg::REPEAT_FOREVER);

    flags_out             = flags_in;
    flags_out.started     = flags_in.started | start;
    word_out              = word_in;
    word_out.phase_stamp  = last;
    drive.en              = start;
    drive.on              = 1'b0;
    drive.led             = flags_in.led;

    if (start) begin
      flags_out.phase = lbsq_pkg::PH_BEGIN;
    end

    if (flags_out.started && !flags_in.done && expired) begin
      case (flags_out.phase)
        lbsq_pkg::PH_BEGIN: begin
          flags_out.phase      = lbsq_pkg::PH_ON;
          drive.en             = 1'b1;
          drive.on             = 1'b1;
          word_out.phase_stamp = now;
        end
        lbsq_pkg::PH_ON: begin
          flags_out.phase      = lbsq_pkg::PH_END;
          drive.en             = 1'b1;
          drive.on             = 1'b0;
          word_out.phase_stamp = now;
        end
        lbsq_pkg::PH_END: begin
          word_out.phase_stamp = now;
          if (again) begin
            flags_out.started   = 1'b0;
            word_out.pass_count = word_in.pass_count + 16'd1;
          end else begin
            flags_out.done = 1'b1;
          end
        end
        default: begin
          // unused phase code: slot stays put
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/led_blink_sequence_queue.sv
// ----------------------------------------------------------------------------
// led_blink_sequence_queue
// Ring of LED blink jobs, swept on millisecond ticks by one shared step unit.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  input   | in_valid, in_stall, opcode .. repeat_count     | item in
//  output  | out_valid, out_stall, accepted, led_levels,    | item out
//          | led_active                                     |
//  config  | cfg_write, cfg_index, cfg_data                 | write only
//
//  enqueue and quit go from idle to finish; a tick goes through the tick state
//  and, when a sweep is due, the sweep state: the step unit visits one slot a
//  cycle, reading slot timing words from the RAM one slot ahead. in_stall is
//  high while an item is at work or its result waits to load; a waiting result
//  is held in the output register, and the next item may enter while it waits.
//  rst is synchronous and clears all slot flags; RAM contents need no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_sequence_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [2:0]  led_number,
  input  wire logic [15:0] on_time_ms,
  input  wire logic [15:0] lead_time_ms,
  input  wire logic [15:0] tail_time_ms,
  input  wire logic [15:0] repeat_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             accepted,
  output logic [7:0]       led_levels,
  output logic             led_active,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_TICK   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  lbsq_pkg::slot_flags_t flags [lbsq_pkg::QUEUE_DEPTH];

  logic [lbsq_pkg::IDX_W-1:0] insert_pointer;
  logic [lbsq_pkg::IDX_W-1:0] slot_sel;
  logic [lbsq_pkg::IDX_W-1:0] proc_idx;
  logic [lbsq_pkg::CNT_W-1:0] cnt;
  logic                       proc_valid;
  logic [31:0]                millisecond_count;
  logic [31:0]                next_sweep_time;
  logic [7:0]                 level_register;
  logic [15:0]                update_interval_ms;
  logic [7:0]                 led_enable_mask;
  logic [2:0]                 item_led;
  logic                       item_accepted;
  logic                       slot_busy;
  logic                       active_now;
  logic                       result_load;

  logic                       ram_we;
  logic [lbsq_pkg::IDX_W-1:0] ram_waddr;
  logic [lbsq_pkg::WORD_W-1:0] ram_wdata;
  logic [lbsq_pkg::WORD_W-1:0] ram_rdata;

  lbsq_pkg::slot_word_t  enq_word;
  lbsq_pkg::slot_word_t  step_word_out;
  lbsq_pkg::slot_flags_t step_flags_out;
  lbsq_pkg::drive_t      step_drive;

  assign in_stall = (state != ST_IDLE);

  assign slot_sel  = (insert_pointer == lbsq_pkg::IDX_W'(lbsq_pkg::QUEUE_DEPTH - 1))
                     ? '0 : insert_pointer + 1'b1;
  assign slot_busy = flags[slot_sel].started & ~flags[slot_sel].done;

  // result register loads once the previous result is gone or leaving
  assign result_load = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    enq_word.on_time      = on_time_ms;
    enq_word.start_delay  = lead_time_ms;
    enq_word.end_delay    = tail_time_ms;
    enq_word.repeat_count = repeat_count;
    enq_word.pass_count   = 16'd0;
    enq_word.phase_stamp  = 32'd0;
  end

  // enqueue writes from idle, sweep writes back the slot just stepped
  always_comb begin
    if (state == ST_SWEEP) begin
      ram_we    = proc_valid;
      ram_waddr = proc_idx;
      ram_wdata = step_word_out;
    end else begin
      ram_we    = (state == ST_IDLE) && in_valid && (opcode == lbsq_pkg::OP_ENQUEUE)
                  && !slot_busy;
      ram_waddr = slot_sel;
      ram_wdata = enq_word;
    end
  end

  lbsq_ram #(
    .WIDTH (lbsq_pkg::WORD_W),
    .DEPTH (lbsq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[lbsq_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  lbsq_step_unit u_step (
    .now       (millisecond_count),
    .flags_in  (flags[proc_idx]),
    .word_in   (lbsq_pkg::slot_word_t'(ram_rdata)),
    .flags_out (step_flags_out),
    .word_out  (step_word_out),
    .drive     (step_drive)
  );

  always_comb begin
    active_now = 1'b0;
    for (int i = 0; i < lbsq_pkg::QUEUE_DEPTH; i++) begin
      if ((flags[i].led == item_led) && flags[i].started) begin
        active_now = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      insert_pointer     <= lbsq_pkg::IDX_W'(lbsq_pkg::QUEUE_DEPTH - 1);
      millisecond_count  <= 32'd0;
      next_sweep_time    <= 32'd0;
      level_register     <= 8'd0;
      update_interval_ms <= lbsq_pkg::UPDATE_INTERVAL_RESET;
      led_enable_mask    <= 8'd0;
      out_valid          <= 1'b0;
      cnt                <= '0;
      proc_valid         <= 1'b0;
      for (int i = 0; i < lbsq_pkg::QUEUE_DEPTH; i++) begin
        flags[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          lbsq_pkg::CFG_UPDATE_INTERVAL: update_interval_ms <= cfg_data;
          lbsq_pkg::CFG_LED_ENABLE_MASK: led_enable_mask    <= cfg_data[7:0];
        endcase
      end

      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item_led      <= led_number;
            item_accepted <= !((opcode == lbsq_pkg::OP_ENQUEUE) && slot_busy);
            case (opcode)
              lbsq_pkg::OP_ENQUEUE: begin
                insert_pointer <= slot_sel;
                if (!slot_busy) begin
                  flags[slot_sel].loaded  <= 1'b1;
                  flags[slot_sel].started <= 1'b0;
                  flags[slot_sel].done    <= 1'b0;
                  flags[slot_sel].phase   <= lbsq_pkg::PH_BEGIN;
                  flags[slot_sel].led     <= led_number;
                end
              end
              lbsq_pkg::OP_QUIT: begin
                level_register <= lbsq_pkg::apply_drive(level_register, led_number, 1'b0,
                                                        led_enable_mask);
                for (int i = 0; i < lbsq_pkg::QUEUE_DEPTH; i++) begin
                  if (flags[i].led == led_number) begin
                    flags[i].done <= 1'b1;
                  end
                end
              end
              lbsq_pkg::OP_TICK: begin
                millisecond_count <= millisecond_count + 32'd1;
              end
              default: begin
              end
            endcase
            state <= (opcode == lbsq_pkg::OP_TICK) ? ST_TICK : ST_FINISH;
          end
        end
        ST_TICK: begin
          if (next_sweep_time <= millisecond_count) begin
            next_sweep_time <= millisecond_count + {16'd0, update_interval_ms};
            cnt             <= '0;
            proc_valid      <= 1'b0;
            state           <= ST_SWEEP;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_SWEEP: begin
          if (proc_valid) begin
            flags[proc_idx] <= step_flags_out;
            if (step_drive.en) begin
              level_register <= lbsq_pkg::apply_drive(level_register, step_drive.led,
                                                      step_drive.on, led_enable_mask);
            end
          end
          // read of slot cnt overlaps the step of slot cnt - 1
          if (cnt < lbsq_pkg::CNT_W'(lbsq_pkg::QUEUE_DEPTH)) begin
            proc_valid <= 1'b1;
            proc_idx   <= cnt[lbsq_pkg::IDX_W-1:0];
            cnt        <= cnt + 1'b1;
          end else begin
            proc_valid <= 1'b0;
            state      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (result_load) begin
            accepted   <= item_accepted;
            led_levels <= level_register;
            led_active <= active_now;
            state      <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/lbsq_checker.sv
// ----------------------------------------------------------------------------
// lbsq_checker
// Port-level checks for the LED blink sequence queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lbsq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       accepted,
  input wire logic [7:0] led_levels,
  input wire logic       led_active
);

  // no result comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // an item keeps the block busy for at least the next cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took no time for an item");

  // a result never appears in the cycle right after its item entered
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !(out_valid && out_stall)) |=> !out_valid || $past(out_valid))
    else $error("result appeared without any work cycle");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(accepted) && $stable(led_levels)
      && $stable(led_active))
    else $error("stalled result changed");

endmodule

bind led_blink_sequence_queue lbsq_checker u_lbsq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .accepted   (accepted),
  .led_levels (led_levels),
  .led_active (led_active)
);

`default_nettype wire
